// File: hdl/bsd_pkg.sv
// Shared types and constants for the byte-stuffing deframer.
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd2;

    localparam logic [BYTE_W-1:0] START_FLAG_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] END_FLAG_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ABORT   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

endpackage

// File: hdl/bsd_front.sv
// Front end: configuration registers, parse state and byte classification.
`timescale 1ns / 1ps

module bsd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [bsd_pkg::BYTE_W-1:0]     i_data,
    input  logic                           i_queue_full,
    output bsd_pkg::t_push                 o_push
);
    import bsd_pkg::*;

    typedef enum logic [2:0] {
        ST_HUNT  = 3'b001,
        ST_FRAME = 3'b010,
        ST_ESC   = 3'b100
    } t_state;

    t_state            r_mode, n_mode;
    logic [BYTE_W-1:0] r_start_flag, r_close_flag, r_escape_byte;
    logic              accept;
    t_push             push;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    assign o_push  = push;

    always_comb begin
        n_mode          = r_mode;
        push.valid      = 1'b0;
        push.cmd.kind   = KIND_PAYLOAD;
        push.cmd.data   = i_data;
        unique case (r_mode)
            ST_ESC: begin
                n_mode     = ST_FRAME;
                push.valid = 1'b1;
            end
            ST_FRAME: begin
                priority if (i_data == r_close_flag) begin
                    n_mode        = ST_HUNT;
                    push.valid    = 1'b1;
                    push.cmd.kind = KIND_DONE;
                    push.cmd.data = '0;
                end else if (i_data == r_start_flag) begin
                    push.valid    = 1'b1;
                    push.cmd.kind = KIND_ABORT;
                    push.cmd.data = '0;
                end else if (i_data == r_escape_byte) begin
                    n_mode = ST_ESC;
                end else begin
                    push.valid = 1'b1;
                end
            end
            default: begin
                n_mode = (i_data == r_start_flag) ? ST_FRAME : ST_HUNT;
            end
        endcase
        if (!accept) begin
            n_mode     = r_mode;
            push.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ST_HUNT;
            r_start_flag  <= START_FLAG_RST;
            r_close_flag  <= END_FLAG_RST;
            r_escape_byte <= ESCAPE_BYTE_RST;
        end else begin
            r_mode <= n_mode;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_FLAG:  r_start_flag  <= i_cfg_data;
                    CFG_END_FLAG:    r_close_flag  <= i_cfg_data;
                    CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: hdl/bsd_queue.sv
// Short command queue between the front end and the output stage.
`timescale 1ns / 1ps

module bsd_queue #(
    parameter int DEPTH = bsd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsd_pkg::t_push i_push,
    output logic           o_full,
    output logic           o_valid,
    output bsd_pkg::t_cmd  o_cmd,
    input  logic           i_pop
);
    import bsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/bsd_back.sv
// Back end: output register that presents results on the master stream.
`timescale 1ns / 1ps

module bsd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  bsd_pkg::t_cmd               i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bsd_pkg::BYTE_W-1:0]  o_data,
    output logic [bsd_pkg::KIND_W-1:0]  o_kind
);
    import bsd_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    t_kind             r_kind;
    logic              load;

    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = load;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= i_q_cmd.data;
            r_kind <= i_q_cmd.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/byte_stuff_deframer_top.sv
// Byte-stuffing deframer: strips start, end and escape framing from a byte stream.
// Usage:
//   Slave stream carries one received byte per transfer in s_axis_tdata.
//   Master stream carries one result per transfer: s payload byte in
//   m_axis_tdata (zero for markers) and its kind in m_axis_tuser
//   (0 payload, 1 frame completed, 2 partial frame aborted by a start flag).
//   Bytes outside a frame, the start flag that opens one and an unescaped escape byte give no transfer.
//   Configuration: write start flag (index 0), end flag (1) and escape byte (2)
//   with i_cfg_we while the stream is idle; other indexes are ignored.
// Timing:
//   One byte accepted per cycle while the queue is not full. A result is written
//   into the command queue when its byte is accepted and is then loaded into the
//   output register. The rate is set by the classify step, which is combinational.
// Reset:
//   Flags return to 2, 3 and 16, parsing hunts for a start flag, queue empties.
// Stall:
//   When the receiver holds m_axis_tready low, the output register holds and
//   the queue fills; s_axis_tready drops once the queue is full.
`timescale 1ns / 1ps

module byte_stuff_deframer_top #(
    parameter int QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsd_pkg::BYTE_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bsd_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bsd_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic [bsd_pkg::KIND_W-1:0]     m_axis_tuser    // [1:0] kind
);
    import bsd_pkg::*;

    t_push push;
    t_cmd  q_cmd;
    logic  q_full, q_valid, q_pop;

    bsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_queue_full (q_full),
        .o_push       (push)
    );

    bsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    bsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_kind    (m_axis_tuser)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the byte-stuffing deframer: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;
    import bsd_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 6;
    localparam int PHASE_ITEMS = 300;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic [1:0] {
        HUNTING  = 2'd0,
        IN_FRAME = 2'd1,
        ESCAPED  = 2'd2
    } t_parse;

    typedef struct {
        logic [BYTE_W-1:0] data;
        t_kind             kind;
    } t_deframed;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_START_FLAG;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [BYTE_W-1:0]    m_tdata;
    logic [KIND_W-1:0]    m_tuser;

    // predictor state
    logic [BYTE_W-1:0] start_flag = START_FLAG_RST;
    logic [BYTE_W-1:0] close_flag = END_FLAG_RST;
    logic [BYTE_W-1:0] esc_byte   = ESCAPE_BYTE_RST;
    t_parse            parse_state = HUNTING;
    t_deframed         pending_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int rx_hold_cycles = 0;
    int rx_gap        = 0;
    bit rx_fast       = 1'b0;
    bit tx_burst      = 1'b0;

    byte_stuff_deframer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_result(input logic [BYTE_W-1:0] data, input t_kind kind);
        t_deframed r;
        r.data = data;
        r.kind = kind;
        pending_results = {pending_results, r};
    endtask

    // Unstuff one accepted byte and queue the result it gives, if any.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        case (parse_state)
            ESCAPED: begin
                parse_state = IN_FRAME;
                push_result(b, KIND_PAYLOAD);
            end
            IN_FRAME: begin
                if (b == close_flag) begin
                    parse_state = HUNTING;
                    push_result('0, KIND_DONE);
                end else if (b == start_flag) begin
                    push_result('0, KIND_ABORT);
                end else if (b == esc_byte) begin
                    parse_state = ESCAPED;
                end else begin
                    push_result(b, KIND_PAYLOAD);
                end
            end
            default: parse_state = (b == start_flag) ? IN_FRAME : HUNTING;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready)
            deframe_byte(s_tdata);
    end

    always @(posedge i_clk) begin
        t_deframed exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_byte %0h kind %0d", m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata !== exp_r.data) begin
                    $error("out_byte mismatch: expected %0h actual %0h", exp_r.data, m_tdata);
                    error_count++;
                end
                if (m_tuser !== exp_r.kind) begin
                    $error("kind mismatch: expected %0d actual %0d", exp_r.kind, m_tuser);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else if (rx_fast) begin
            m_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_gap = gap_len();
        end
    end

    task automatic idle_sender(input int n);
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        if (!tx_burst && $urandom_range(0, 9) < 4)
            idle_sender(gap_len());
    endtask

    // Hold the sender until every result is out, then let the block settle.
    task automatic wait_idle();
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_FLAG:  start_flag = val;
            CFG_END_FLAG:    close_flag = val;
            CFG_ESCAPE_BYTE: esc_byte   = val;
            default: ;
        endcase
    endtask

    task automatic set_flags(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                             input logic [BYTE_W-1:0] x);
        wait_idle();
        write_reg(CFG_START_FLAG, s);
        write_reg(CFG_END_FLAG, e);
        write_reg(CFG_ESCAPE_BYTE, x);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return start_flag;
            1: return close_flag;
            2: return esc_byte;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bit is_flag(input logic [BYTE_W-1:0] b);
        return b == start_flag || b == close_flag || b == esc_byte;
    endfunction

    // Mostly well-formed frames; some raw flags, missing ends and noise.
    task automatic send_frame(input int max_len);
        logic [BYTE_W-1:0] b;
        int len;
        send_byte(start_flag);
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++) begin
            b = pick_byte();
            if (is_flag(b) && $urandom_range(0, 9) != 0)
                send_byte(esc_byte);
            send_byte(b);
        end
        case ($urandom_range(0, 19))
            0: ;
            1: begin
                send_byte(esc_byte);
                send_byte(close_flag);
            end
            default: send_byte(close_flag);
        endcase
        if ($urandom_range(0, 9) < 3) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_byte(pick_byte());
        end
    endtask

    task automatic test_default_flags();
        logic [BYTE_W-1:0] seq[$];
        seq = '{8'h00, 8'hFF, 8'h10, 8'h03, 8'h02, 8'h00, 8'hFF, 8'h10, 8'h03,
                8'h10, 8'h10, 8'h10, 8'h02, 8'h02, 8'h02, 8'hAA, 8'h03};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_shared_flags();
        logic [BYTE_W-1:0] seq[$];
        set_flags(8'h7E, 8'h7E, 8'h7D);
        seq = '{8'h7E, 8'h41, 8'h7E, 8'h7E, 8'h7D, 8'h7E, 8'h7E};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
        write_reg(CFG_ESCAPE_BYTE, 8'h7E);
        write_reg(CFG_UNUSED_IDX, 8'h55);
        send_byte(8'h7E);
        send_byte(8'h7E);
        set_flags(8'hFF, 8'h00, 8'hFF);
        seq = '{8'hFF, 8'hFF, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_random_streams();
        logic [BYTE_W-1:0] s;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_flags(START_FLAG_RST, END_FLAG_RST, ESCAPE_BYTE_RST);
                1: set_flags(8'h00, 8'hFF, 8'h80);
                2: set_flags(8'hFF, 8'h00, 8'h7F);
                3: begin
                    s = BYTE_W'($urandom_range(0, 255));
                    set_flags(s, s, BYTE_W'($urandom_range(0, 255)));
                end
                default: set_flags(BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)),
                                   BYTE_W'($urandom_range(0, 255)));
            endcase
            tx_burst = (phase == 4);
            rx_fast  = (phase == 4);
            bytes_sent = 0;
            while (bytes_sent < PHASE_ITEMS)
                send_frame(($urandom_range(0, 7) == 0) ? 40 : 8);
        end
        tx_burst = 1'b0;
        rx_fast  = 1'b0;
    endtask

    task automatic test_backpressure();
        logic [BYTE_W-1:0] b;
        set_flags(8'h7E, 8'h7F, 8'h7D);
        @(posedge i_clk);
        rx_hold_cycles = 300;
        tx_burst = 1'b1;
        send_byte(start_flag);
        for (int i = 0; i < 40; i++) begin
            do b = BYTE_W'($urandom_range(0, 255)); while (is_flag(b));
            send_byte(b);
        end
        send_byte(close_flag);
        tx_burst = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_flags();
        test_shared_flags();
        test_backpressure();
        test_random_streams();
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
